// ===== hw/rtl/bps_pkg.sv =====
// Package for the byte pattern search unit: sizes, register indexes and the
// control bundle handed from the top level to the match tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

   // Longest pattern the cell row supports, and width of the byte counter
   localparam int PATTERN_MAX = 16;
   localparam int OFFSET_BITS = 32;

   // Field and register widths
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 5;
   localparam int CFG_W    = 64;
   localparam int INDEX_W  = 8;
   localparam int RESULT_W = 32;
   localparam int SEL_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   // Configuration register indexes
   localparam logic [INDEX_W-1:0] REG_PATTERN_LOW  = INDEX_W'(0);
   localparam logic [INDEX_W-1:0] REG_PATTERN_HIGH = INDEX_W'(1);
   localparam logic [INDEX_W-1:0] REG_PATTERN_LEN  = INDEX_W'(2);
   localparam logic [INDEX_W-1:0] REG_SEARCH_MODE  = INDEX_W'(3);

   // Search modes
   localparam logic MODE_FIRST = 1'b0;
   localparam logic MODE_LAST  = 1'b1;

   // Per-byte control handed to the match tracker
   typedef struct packed {
      logic             accept;
      logic             last;
      logic             hit;
      logic             mode;
      logic [LEN_W-1:0] len_m1;
   } bps_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bps_cell.sv =====
// One cell of the compare row: holds the partial-match bit for one pattern
// position and hands it to its right neighbor. Depends on bps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bps_cell
   import bps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              clear,
   input  wire logic              prev_match,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic [BYTE_W-1:0] pattern_byte,
   output logic                   match_now,
   output logic                   match_ff
);

   logic match_in;

   // Extend the neighbor's partial match by the incoming byte
   assign match_now = prev_match && (data_byte == pattern_byte);

   always_comb begin
      match_in = match_ff;
      if (advance) begin
         match_in = clear ? 1'b0 : match_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bps_tracker.sv =====
// Match tracker: byte counter, recorded match offset and the result register.
// Depends on bps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bps_tracker
   import bps_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bps_ctl_type         ctl,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_found,
   output logic [RESULT_W-1:0]      rsp_match_offset
);

   logic [OFFSET_BITS-1:0] count_ff, count_in;
   logic                   seen_ff, seen_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic [RESULT_W-1:0]    offset_ff, offset_in;
   logic                   upd_seen;
   logic [OFFSET_BITS-1:0] upd_pos;
   logic [63:0]            pos_wide;

   // Fold the current byte's hit into the recorded match
   always_comb begin
      upd_seen = seen_ff;
      upd_pos  = pos_ff;
      if (ctl.hit) begin
         if (ctl.mode == MODE_LAST) begin
            upd_seen = 1'b1;
            upd_pos  = count_ff;
         end else if (!seen_ff) begin
            upd_seen = 1'b1;
            upd_pos  = count_ff - OFFSET_BITS'(ctl.len_m1);
         end
      end
   end

   assign pos_wide = 64'(upd_pos);

   // Advance the search state; clear it and load the result on the last byte
   always_comb begin
      count_in     = count_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      offset_in    = offset_ff;
      if (ctl.accept) begin
         if (ctl.last) begin
            count_in     = '0;
            seen_in      = 1'b0;
            pos_in       = '0;
            rsp_valid_in = 1'b1;
            found_in     = upd_seen;
            offset_in    = upd_seen ? pos_wide[RESULT_W-1:0] : '0;
         end else begin
            count_in = count_ff + OFFSET_BITS'(1);
            seen_in  = upd_seen;
            pos_in   = upd_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload holds while the transfer is pending
   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_match_offset = offset_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/byte_pattern_search_unit.sv =====
// Top level of the byte pattern search unit: configuration registers, the
// row of compare cells and the match tracker. Depends on bps_pkg, bps_cell
// and bps_tracker.
//
// Usage: write the pattern bytes, pattern length (1..16) and search mode on
// the csr_ channel while the unit is idle; writes are taken in every cycle.
// Stream the buffer one byte per req_ transfer, marking the final byte with
// req_last_byte. Every byte is compared against all pattern positions at
// once by a row of cells, each holding the partial-match bit of one pattern
// position, so the unit takes one byte per cycle except while a last byte is held back.
// One rsp_ transfer follows each buffer: it becomes valid the cycle after the
// last byte is taken. First mode gives the start offset of the earliest
// match, last mode the offset of the final byte of the latest match; not
// found gives offset zero. The search state clears with the last byte, so
// the next buffer may start in the following cycle.
// While a result waits on rsp_ready, bytes keep flowing; only a further last
// byte is held back (req_ready low) until the pending result is taken.
// Reset clears the search state and loads the register defaults (pattern
// zero, length one, first mode).
`timescale 1ns / 1ps
`default_nettype none

module byte_pattern_search_unit
   import bps_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [INDEX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]    csr_wdata,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [BYTE_W-1:0]   req_data_byte,
   input  wire logic                req_last_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_found,
   output logic [RESULT_W-1:0]      rsp_match_offset
);

   logic [CFG_W-1:0]       pat_low_ff, pat_low_in;
   logic [CFG_W-1:0]       pat_high_ff, pat_high_in;
   logic [LEN_W-1:0]       pat_len_ff, pat_len_in;
   logic                   mode_ff, mode_in;
   logic [LEN_W-1:0]       eff_len;
   logic [LEN_W-1:0]       len_m1;
   logic [SEL_W-1:0]       hit_sel;
   logic                   accept;
   logic [PATTERN_MAX-1:0] cell_now;
   logic [PATTERN_MAX-1:0] cell_ff;
   bps_ctl_type            ctl;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes drop
   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in  = pat_len_ff;
      mode_in     = mode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PATTERN_LOW:  pat_low_in  = csr_wdata;
            REG_PATTERN_HIGH: pat_high_in = csr_wdata;
            REG_PATTERN_LEN:  pat_len_in  = csr_wdata[LEN_W-1:0];
            REG_SEARCH_MODE:  mode_in     = csr_wdata[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= LEN_W'(1);
         mode_ff     <= MODE_FIRST;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         pat_len_ff  <= pat_len_in;
         mode_ff     <= mode_in;
      end
   end

   // Clamp the length to 1..PATTERN_MAX
   always_comb begin
      eff_len = pat_len_ff;
      if (pat_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (pat_len_ff > LEN_W'(PATTERN_MAX)) begin
         eff_len = LEN_W'(PATTERN_MAX);
      end
   end

   assign len_m1  = eff_len - LEN_W'(1);
   assign hit_sel = len_m1[SEL_W-1:0];

   // Hold back a last byte only while a result is still pending
   assign req_ready = !(req_last_byte && rsp_valid && !rsp_ready);
   assign accept    = req_valid && req_ready;

   // Row of compare cells, one per pattern position
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [BYTE_W-1:0] pat_byte;
      logic              prev;

      if (k < 8) begin : g_low
         assign pat_byte = pat_low_ff[BYTE_W*k +: BYTE_W];
      end else begin : g_high
         assign pat_byte = pat_high_ff[BYTE_W*(k-8) +: BYTE_W];
      end

      if (k == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = cell_ff[k-1];
      end

      bps_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (accept),
         .clear        (req_last_byte),
         .prev_match   (prev),
         .data_byte    (req_data_byte),
         .pattern_byte (pat_byte),
         .match_now    (cell_now[k]),
         .match_ff     (cell_ff[k])
      );
   end

   // Full match when the cell at the pattern's final position matches
   always_comb begin
      ctl.accept = accept;
      ctl.last   = req_last_byte;
      ctl.hit    = cell_now[hit_sel];
      ctl.mode   = mode_ff;
      ctl.len_m1 = len_m1;
   end

   bps_tracker u_tracker (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset)
   );

   // A buffer's last byte produces a result in the next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> rsp_valid)
      else $error("no result after last byte transfer");

   // Partial matches never carry over into the next buffer
   a_cells_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> cell_ff == '0)
      else $error("cell row not cleared after last byte");

   // A result without a match reports offset zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("nonzero offset on a miss");

   // Input stalls only behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a pending result");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for byte_pattern_search_unit: streams byte buffers on
// req_, predicts each search result and compares every rsp_ transfer with it.
// Depends on bps_pkg and the byte_pattern_search_unit RTL.
`timescale 1ns / 1ps

module testbench
   import bps_pkg::*;
;

   localparam int BYTE_TARGET  = 1950;
   localparam int DRAIN_CYCLES = 6;

   typedef logic [BYTE_W-1:0] byte_q_type [$];

   typedef struct packed {
      logic                found;
      logic [RESULT_W-1:0] offset;
   } search_result_type;

   logic                clock;
   logic                reset;
   logic                csr_valid;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index;
   logic [CFG_W-1:0]    csr_wdata;
   logic                req_valid;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte;
   logic                req_last_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_found;
   logic [RESULT_W-1:0] rsp_match_offset;

   byte_pattern_search_unit dut (.*);

   // Predictor copy of the registers and the search state
   logic [CFG_W-1:0]       pat_lo_r;
   logic [CFG_W-1:0]       pat_hi_r;
   logic [LEN_W-1:0]       pat_len_r;
   logic                   mode_r;
   logic [BYTE_W-1:0]      win_q [PATTERN_MAX];
   int                     win_depth;
   logic [OFFSET_BITS-1:0] buf_offset;
   logic                   hit_held;
   logic [OFFSET_BITS-1:0] hit_offset;

   search_result_type predicted_results [$];

   // Stimulus side: pattern last written, sender burst state, run statistics
   logic [2*CFG_W-1:0] gen_pattern;
   int                 gen_len;
   int                 burst_left;
   int                 error_count;
   int                 bytes_sent;
   int                 buffers_sent;
   int                 found_count;
   int                 setting_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      error_count++;
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
   endtask

   // Clear the per-buffer search state
   function automatic void restart_buffer();
      int k;
      for (k = 0; k < PATTERN_MAX; k++)
         win_q[k] = '0;
      win_depth  = 0;
      buf_offset = '0;
      hit_held   = 1'b0;
      hit_offset = '0;
   endfunction

   function automatic void apply_csr(input logic [INDEX_W-1:0] idx,
                                     input logic [CFG_W-1:0] value);
      case (idx)
         REG_PATTERN_LOW:  pat_lo_r  = value;
         REG_PATTERN_HIGH: pat_hi_r  = value;
         REG_PATTERN_LEN:  pat_len_r = value[LEN_W-1:0];
         REG_SEARCH_MODE:  mode_r    = value[0];
         default: ;
      endcase
   endfunction

   // Shift one byte into the window, compare, and queue a result on the last byte
   function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic is_last);
      int                 len;
      int                 k;
      logic               hit;
      logic [2*CFG_W-1:0] pat;
      search_result_type  res;
      len = int'(pat_len_r);
      if (len == 0)
         len = 1;
      if (len > PATTERN_MAX)
         len = PATTERN_MAX;
      pat = {pat_hi_r, pat_lo_r};
      for (k = PATTERN_MAX - 1; k > 0; k--)
         win_q[k] = win_q[k-1];
      win_q[0] = b;
      if (win_depth < PATTERN_MAX)
         win_depth++;
      // win_q[j] holds the byte at buf_offset - j; pattern byte 0 is the oldest
      hit = (win_depth >= len);
      for (k = 0; k < len; k++)
         if (win_q[len-1-k] != pat[8*k +: 8])
            hit = 1'b0;
      if (hit) begin
         if (mode_r == MODE_LAST) begin
            hit_offset = buf_offset;
            hit_held   = 1'b1;
         end else if (!hit_held) begin
            hit_offset = buf_offset - OFFSET_BITS'(len - 1);
            hit_held   = 1'b1;
         end
      end
      buf_offset++;
      if (is_last) begin
         res.found  = hit_held;
         res.offset = hit_held ? RESULT_W'(hit_offset) : '0;
         if (hit_held)
            found_count++;
         predicted_results.push_back(res);
         restart_buffer();
      end
   endfunction

   // Check result transfers, then track register writes and byte transfers
   always @(posedge clock) begin : scoreboard
      search_result_type want;
      if (reset) begin
         pat_lo_r  = '0;
         pat_hi_r  = '0;
         pat_len_r = LEN_W'(1);
         mode_r    = MODE_FIRST;
         restart_buffer();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               report_mismatch("result with none pending", 64'h0,
                               {31'h0, rsp_found, rsp_match_offset});
            end else begin
               want = predicted_results.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", 64'(want.found), 64'(rsp_found));
               if (rsp_match_offset !== want.offset)
                  report_mismatch("match_offset", 64'(want.offset), 64'(rsp_match_offset));
            end
         end
         if (csr_valid && csr_ready)
            apply_csr(csr_index, csr_wdata);
         if (req_valid && req_ready)
            scan_byte(req_data_byte, req_last_byte);
      end
   end

   // Receiver: stall on a pattern that changes style after each random span
   initial begin : result_stalls
      int span;
      int style;
      rsp_ready = 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(8, 60);
         repeat (span) begin
            @(negedge clock);
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 7) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // Sender idle pattern: bursts of random length, random gaps between them
   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 40);
      case ($urandom_range(0, 5))
         0, 1: return 0;
         5: return $urandom_range(8, 20);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_buffer(input byte_q_type bytes);
      int i;
      for (i = 0; i < bytes.size(); i++)
         send_byte(bytes[i], i == bytes.size() - 1, next_gap());
      buffers_sent++;
   endtask

   // Drop valid, wait for every pending result, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Write all four registers and keep the effective pattern for the generator
   task automatic set_search(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [CFG_W-1:0] len_word,
                             input logic [CFG_W-1:0] mode_word);
      int len;
      len = int'(len_word[LEN_W-1:0]);
      if (len == 0)
         len = 1;
      if (len > PATTERN_MAX)
         len = PATTERN_MAX;
      gen_pattern = {hi, lo};
      gen_len     = len;
      csr_write(REG_PATTERN_LOW, lo);
      csr_write(REG_PATTERN_HIGH, hi);
      csr_write(REG_PATTERN_LEN, len_word);
      csr_write(REG_SEARCH_MODE, mode_word);
      setting_count++;
   endtask

   // Reset values: pattern byte zero, length one, first mode
   task automatic test_reset_defaults();
      send_buffer('{8'hFF, 8'h00});
   endtask

   // Overlapping matches in last mode report the end of the latest one
   task automatic test_overlap_last_mode();
      wait_idle();
      set_search(64'hA5A5, 64'h0, 64'd2, CFG_W'(MODE_LAST));
      send_buffer('{8'hA5, 8'hA5, 8'hA5});
   endtask

   // Buffer shorter than the pattern; mode word with upper bits set selects first
   task automatic test_short_buffer();
      wait_idle();
      set_search(64'hA5A5A5, 64'h0, 64'd3, 64'hFFFF_FFFF_FFFF_FFFE);
      send_buffer('{8'hA5});
   endtask

   // Length zero behaves as one
   task automatic test_zero_length();
      wait_idle();
      set_search(64'h11A5, 64'h0, 64'd0, CFG_W'(MODE_FIRST));
      send_buffer('{8'h11, 8'hA5});
   endtask

   // Length above the maximum behaves as sixteen; buffer is exactly the pattern
   task automatic test_length_above_max();
      byte_q_type bytes;
      int         k;
      wait_idle();
      set_search(64'h00FF_00FF_FF00_FF00, 64'hFF00_00FF_00FF_FF00, 64'd31,
                 CFG_W'(MODE_LAST));
      for (k = 0; k < PATTERN_MAX; k++)
         bytes.push_back(gen_pattern[8*k +: 8]);
      send_buffer(bytes);
   endtask

   // Writes to unused indexes leave the registers alone
   task automatic test_unused_index();
      wait_idle();
      set_search(64'h3C, 64'h0, 64'd1, CFG_W'(MODE_FIRST));
      csr_write(INDEX_W'(4), '1);
      csr_write('1, '1);
      send_buffer('{8'h3C});
   endtask

   // Random settings, each followed by buffers built around the pattern
   task automatic test_random_buffers();
      byte_q_type       bytes;
      logic [CFG_W-1:0] lo;
      logic [CFG_W-1:0] hi;
      logic [CFG_W-1:0] len_word;
      int               n;
      int               i;
      int               p;
      int               k;
      int               nbuf;
      int               copies;
      logic             noise;
      while (bytes_sent < BYTE_TARGET) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0: begin
               lo = '0;
               hi = '0;
            end
            1: begin
               lo = '1;
               hi = '1;
            end
            default: begin
               lo = {$urandom, $urandom};
               hi = {$urandom, $urandom};
            end
         endcase
         case ($urandom_range(0, 5))
            0: len_word = 64'd1;
            1: len_word = 64'd16;
            2: len_word = {$urandom, $urandom};
            default: len_word = CFG_W'($urandom_range(1, 6));
         endcase
         set_search(lo, hi, len_word, {$urandom, $urandom});
         if ($urandom_range(0, 7) == 0)
            csr_write(INDEX_W'($urandom_range(4, 255)), {$urandom, $urandom});
         nbuf = $urandom_range(2, 8);
         repeat (nbuf) begin
            // mostly pattern bytes with planted copies; some pure noise
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80)
                                             : $urandom_range(1, gen_len + 12);
            noise = ($urandom_range(0, 7) == 0);
            bytes = {};
            for (i = 0; i < n; i++) begin
               k = $urandom_range(0, gen_len - 1);
               if (noise || $urandom_range(0, 3) == 0)
                  bytes.push_back(BYTE_W'($urandom));
               else
                  bytes.push_back(gen_pattern[8*k +: 8]);
            end
            if (!noise && n >= gen_len) begin
               copies = $urandom_range(0, 2);
               repeat (copies) begin
                  p = $urandom_range(0, n - gen_len);
                  for (k = 0; k < gen_len; k++)
                     bytes[p+k] = gen_pattern[8*k +: 8];
                  // spoil one byte now and then for a near miss
                  if ($urandom_range(0, 3) == 0) begin
                     k = p + $urandom_range(0, gen_len - 1);
                     bytes[k] = bytes[k] ^ BYTE_W'(1 << $urandom_range(0, 7));
                  end
               end
            end
            send_buffer(bytes);
         end
      end
   endtask

   initial begin : run_sequence
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      gen_pattern   = '0;
      gen_len       = 1;
      burst_left    = 0;
      error_count   = 0;
      bytes_sent    = 0;
      buffers_sent  = 0;
      found_count   = 0;
      setting_count = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_overlap_last_mode();
      test_short_buffer();
      test_zero_length();
      test_length_above_max();
      test_unused_index();
      test_random_buffers();
      wait_idle();

      $display("Searched %0d bytes in %0d buffers (%0d with a match) over %0d settings",
               bytes_sent, buffers_sent, found_count, setting_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Hold a hard limit on the run length
   initial begin : watchdog
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
